FILE: hdl/rpc_pkg.sv
// Shared types and constants for the retransmit packet cache.
// Used by the top-level sequencer; depends on nothing.
`timescale 1ns / 1ps
package rpc_pkg;

    localparam int SLOTS_DEF      = 8192;
    localparam int RING_DEPTH_DEF = 16384;

    localparam logic [15:0] DEF_MAX_AGE     = 16'd2000;
    localparam logic [12:0] DEF_MAX_ENTRIES = 13'd4096;
    localparam logic [31:0] DEF_MAX_BYTES   = 32'd8388608;

    localparam int CFG_W     = 32;
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_AGE     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_ENTRIES = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_BYTES   = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_RESEND_GAP  = 2'd3;

    localparam logic [1:0] REQ_STORE  = 2'd0;
    localparam logic [1:0] REQ_LOOKUP = 2'd1;
    localparam logic [1:0] REQ_REPORT = 2'd2;
    localparam logic [1:0] REQ_CLEAR  = 2'd3;

    localparam logic [2:0] STAT_INSERTED   = 3'd0;
    localparam logic [2:0] STAT_REPLACED   = 3'd1;
    localparam logic [2:0] STAT_IGNORED    = 3'd2;
    localparam logic [2:0] STAT_MISS       = 3'd3;
    localparam logic [2:0] STAT_SUPPRESSED = 3'd4;
    localparam logic [2:0] STAT_HIT        = 3'd5;
    localparam logic [2:0] STAT_REPORTED   = 3'd6;
    localparam logic [2:0] STAT_CLEARED    = 3'd7;

    localparam int S_DATA_W = 128;
    localparam int M_DATA_W = 224;

    typedef struct packed {
        logic        valid;
        logic [47:0] key;
        logic [31:0] handle;
        logic [15:0] length;
        logic [31:0] stored;
        logic        rflag;
        logic [31:0] rtime;
        logic [31:0] serial;
    } slot_word_t;

    localparam int SLOT_W = $bits(slot_word_t);

    typedef enum logic [3:0] {
        ST_SWEEP, ST_IDLE, ST_WCHK, ST_WRING, ST_WSLOT,
        ST_SCAN, ST_STORE, ST_LOOK, ST_RESP
    } state_t;

    typedef enum logic [1:0] {
        WM_AGE, WM_CAP, WM_OVF, WM_FULL
    } walk_mode_t;

endpackage

FILE: hdl/rpc_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
// Standalone; used for the slot table and the insertion-order ring.
`timescale 1ns / 1ps
module rpc_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end
endmodule

FILE: hdl/retransmit_packet_cache.sv
// Top level of the retransmit packet cache: request sequencer and counters.
// Depends on rpc_pkg and instantiates rpc_ram for the slot table and order ring.
`timescale 1ns / 1ps
// Usage: a request word enters on the s_ channel (kind in s_tuser) and exactly
// one result word leaves on the m_ channel (status in m_tuser). Registers are
// written through cfg_wr_en / cfg_index / cfg_wr_data; the user must do so only
// while the block is idle, which it does not enforce. One request is worked on
// at a time; s_tready is high only when idle. The memories are read one entry
// per cycle: each record from the front of the order ring passes ST_WCHK,
// ST_WRING and ST_WSLOT; a key search reads slots one per cycle, stopping on
// a match, at the last slot, or once all live entries are seen and, for a
// store, a free slot found. A clear request sweeps the slot table; an ignored
// store (zero stream_id or length) goes straight to its result. After reset
// all SLOTS slots (8192 by default) are swept, taking no request; configuration
// writes are taken always. The result sits in an output register; a stalled
// receiver holds it there, and the next request is finished before waiting.
module retransmit_packet_cache #(
    parameter int SLOTS      = rpc_pkg::SLOTS_DEF,
    parameter int RING_DEPTH = rpc_pkg::RING_DEPTH_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // stream_id, sequence_number, packet_length, packet_handle, now_ms
    input  logic [rpc_pkg::S_DATA_W-1:0]  s_tdata,
    // req_type
    input  logic [1:0]                    s_tuser,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // hit_handle, hit_length, live_entries, live_bytes, inserted_total,
    // replaced_total, age_evicted_total, capacity_evicted_total, zero pad
    output logic [rpc_pkg::M_DATA_W-1:0]  m_tdata,
    // status
    output logic [2:0]                    m_tuser,
    input  logic                          cfg_wr_en,
    input  logic [rpc_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [rpc_pkg::CFG_W-1:0]     cfg_wr_data
);
    import rpc_pkg::*;

    localparam int SAW = $clog2(SLOTS);
    localparam int RAW = $clog2(RING_DEPTH);
    localparam int EW  = $clog2(SLOTS + 1);
    localparam int RW  = SAW + 32;
    localparam logic [SAW-1:0] SLOT_LAST  = SAW'(SLOTS - 1);
    localparam logic [SAW:0]   SLOT_CNT   = (SAW+1)'(SLOTS);
    localparam logic [RAW-1:0] RING_LAST  = RAW'(RING_DEPTH - 1);
    localparam logic [RAW:0]   RING_FULL  = (RAW+1)'(RING_DEPTH);
    localparam logic [RAW+1:0] RING_WRAP  = (RAW+2)'(RING_DEPTH);

    state_t     state_reg, state_next;
    walk_mode_t mode_reg, mode_next;
    logic       post_reg, post_next;
    logic       clr_resp_reg, clr_resp_next;

    logic [15:0] max_age_reg, max_age_next;
    logic [12:0] max_ent_reg, max_ent_next;
    logic [31:0] max_bytes_reg, max_bytes_next;
    logic [15:0] gap_reg, gap_next;

    logic [RAW-1:0] head_reg, head_next;
    logic [RAW:0]   fill_reg, fill_next;
    logic [31:0]    serial_reg, serial_next;
    logic [EW-1:0]  entries_reg, entries_next;
    logic [31:0]    bytes_reg, bytes_next;
    logic [31:0]    ins_reg, ins_next, rep_reg, rep_next;
    logic [31:0]    age_cnt_reg, age_cnt_next, cap_cnt_reg, cap_cnt_next;

    logic [SAW:0]   scan_idx_reg, scan_idx_next;
    logic           pend_reg, pend_next;
    logic [SAW-1:0] pend_idx_reg, pend_idx_next;
    logic [EW-1:0]  seen_reg, seen_next;
    logic           free_found_reg, free_found_next;
    logic [SAW-1:0] free_slot_reg, free_slot_next;
    logic           found_reg, found_next;
    slot_word_t     cur_reg, cur_next;
    logic [SAW-1:0] cur_slot_reg, cur_slot_next;

    logic [1:0]  req_reg, req_next;
    logic [31:0] sid_reg, sid_next;
    logic [15:0] seq_reg, seq_next;
    logic [15:0] len_reg, len_next;
    logic [31:0] handle_reg, handle_next;
    logic [31:0] now_reg, now_next;

    logic [2:0]  status_reg, status_next;
    logic [31:0] hh_reg, hh_next;
    logic [15:0] hl_reg, hl_next;

    logic                m_valid_reg, m_valid_next;
    logic [M_DATA_W-1:0] m_data_reg, m_data_next;
    logic [2:0]          m_user_reg, m_user_next;

    logic                slot_we, slot_re;
    logic [SAW-1:0]      slot_waddr, slot_raddr;
    logic [SLOT_W-1:0]   slot_wdata, slot_rdata;
    logic                ring_we, ring_re;
    logic [RAW-1:0]      ring_waddr, ring_raddr;
    logic [RW-1:0]       ring_wdata, ring_rdata;

    slot_word_t     sw;
    logic [SAW-1:0] rec_slot;
    logic [31:0]    rec_serial;
    logic [47:0]    key;
    logic           over, walk_go, live, too_old;
    logic           pd_match, free_after, scan_end, is_lookup;
    logic [EW-1:0]  seen_after;
    logic [RAW-1:0] head_inc;
    logic [RAW+1:0] tail_sum;
    logic [RAW-1:0] tail;
    logic [31:0]    entries32;
    state_t         dispatch;

    rpc_ram #(.WIDTH(SLOT_W), .DEPTH(SLOTS)) u_slot_ram (
        .aclk (aclk), .we (slot_we), .waddr (slot_waddr), .wdata (slot_wdata),
        .re (slot_re), .raddr (slot_raddr), .rdata (slot_rdata)
    );

    rpc_ram #(.WIDTH(RW), .DEPTH(RING_DEPTH)) u_ring_ram (
        .aclk (aclk), .we (ring_we), .waddr (ring_waddr), .wdata (ring_wdata),
        .re (ring_re), .raddr (ring_raddr), .rdata (ring_rdata)
    );

    assign sw         = slot_word_t'(slot_rdata);
    assign rec_slot   = ring_rdata[RW-1:32];
    assign rec_serial = ring_rdata[31:0];
    assign key        = {sid_reg, seq_reg};
    assign entries32  = 32'(entries_reg);
    assign is_lookup  = (req_reg == REQ_LOOKUP);

    assign over    = (entries32 > 32'(max_ent_reg)) || (bytes_reg > max_bytes_reg);
    assign live    = sw.valid && (sw.serial == rec_serial);
    assign too_old = (now_reg - sw.stored) > 32'(max_age_reg);

    assign head_inc = (head_reg == RING_LAST) ? '0 : head_reg + 1'b1;
    assign tail_sum = (RAW+2)'(head_reg) + (RAW+2)'(fill_reg);
    assign tail     = (tail_sum >= RING_WRAP) ? RAW'(tail_sum - RING_WRAP) : RAW'(tail_sum);

    assign pd_match   = pend_reg && sw.valid && (sw.key == key);
    assign seen_after = seen_reg + EW'(pend_reg && sw.valid);
    assign free_after = free_found_reg || (pend_reg && !sw.valid);
    assign scan_end   = (pend_reg && (pend_idx_reg == SLOT_LAST)) ||
                        ((seen_after == entries_reg) && (is_lookup || free_after));

    always_comb begin
        case (mode_reg)
            WM_AGE:  walk_go = (fill_reg != '0);
            WM_CAP:  walk_go = (fill_reg != '0) && over;
            WM_OVF:  walk_go = 1'b1;
            WM_FULL: walk_go = (fill_reg != '0);
            default: walk_go = 1'b0;
        endcase
    end

    always_comb begin
        if (post_reg) begin
            dispatch = ST_RESP;
        end else begin
            case (req_reg)
                REQ_STORE:  dispatch = (fill_reg == RING_FULL) ? ST_WCHK : ST_SCAN;
                REQ_LOOKUP: dispatch = ST_SCAN;
                default:    dispatch = ST_RESP;
            endcase
        end
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_SWEEP: begin
                if (scan_idx_reg[SAW-1:0] == SLOT_LAST) begin
                    state_next = clr_resp_reg ? ST_RESP : ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (s_tvalid) begin
                    if (s_tuser == REQ_CLEAR) begin
                        state_next = ST_SWEEP;
                    end else if (s_tuser == REQ_STORE &&
                                 (s_tdata[31:0] == '0 || s_tdata[63:48] == '0)) begin
                        state_next = ST_RESP;
                    end else begin
                        state_next = ST_WCHK;
                    end
                end
            end
            ST_WCHK: begin
                if (walk_go) begin
                    state_next = ST_WRING;
                end else begin
                    case (mode_reg)
                        WM_AGE:  state_next = ST_WCHK;
                        WM_CAP:  state_next = dispatch;
                        WM_FULL: state_next = ST_STORE;
                        default: state_next = ST_SCAN;
                    endcase
                end
            end
            ST_WRING: state_next = ST_WSLOT;
            ST_WSLOT: begin
                case (mode_reg)
                    WM_OVF:  state_next = ST_SCAN;
                    WM_FULL: state_next = live ? ST_STORE : ST_WCHK;
                    default: state_next = ST_WCHK;
                endcase
            end
            ST_SCAN: begin
                if (pd_match) begin
                    state_next = is_lookup ? ST_LOOK : ST_STORE;
                end else if (scan_end) begin
                    if (is_lookup) begin
                        state_next = ST_RESP;
                    end else begin
                        state_next = free_after ? ST_STORE : ST_WCHK;
                    end
                end
            end
            ST_STORE: state_next = ST_WCHK;
            ST_LOOK:  state_next = ST_RESP;
            ST_RESP: begin
                if (!m_valid_reg || m_tready) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        mode_next       = mode_reg;
        post_next       = post_reg;
        clr_resp_next   = clr_resp_reg;
        max_age_next    = max_age_reg;
        max_ent_next    = max_ent_reg;
        max_bytes_next  = max_bytes_reg;
        gap_next        = gap_reg;
        head_next       = head_reg;
        fill_next       = fill_reg;
        serial_next     = serial_reg;
        entries_next    = entries_reg;
        bytes_next      = bytes_reg;
        ins_next        = ins_reg;
        rep_next        = rep_reg;
        age_cnt_next    = age_cnt_reg;
        cap_cnt_next    = cap_cnt_reg;
        scan_idx_next   = scan_idx_reg;
        pend_next       = pend_reg;
        pend_idx_next   = pend_idx_reg;
        seen_next       = seen_reg;
        free_found_next = free_found_reg;
        free_slot_next  = free_slot_reg;
        found_next      = found_reg;
        cur_next        = cur_reg;
        cur_slot_next   = cur_slot_reg;
        req_next        = req_reg;
        sid_next        = sid_reg;
        seq_next        = seq_reg;
        len_next        = len_reg;
        handle_next     = handle_reg;
        now_next        = now_reg;
        status_next     = status_reg;
        hh_next         = hh_reg;
        hl_next         = hl_reg;
        m_valid_next    = m_valid_reg && !m_tready;
        m_data_next     = m_data_reg;
        m_user_next     = m_user_reg;
        slot_we         = 1'b0;
        slot_waddr      = cur_slot_reg;
        slot_wdata      = slot_rdata;
        slot_re         = 1'b0;
        slot_raddr      = rec_slot;
        ring_we         = 1'b0;
        ring_waddr      = tail;
        ring_wdata      = {cur_slot_reg, serial_reg};
        ring_re         = 1'b0;
        ring_raddr      = head_reg;

        if (cfg_wr_en) begin
            case (cfg_index)
                CFG_MAX_AGE: begin
                    max_age_next = (cfg_wr_data[15:0] == '0) ? DEF_MAX_AGE
                                                              : cfg_wr_data[15:0];
                end
                CFG_MAX_ENTRIES: begin
                    max_ent_next = (cfg_wr_data[12:0] == '0) ? DEF_MAX_ENTRIES
                                                              : cfg_wr_data[12:0];
                end
                CFG_MAX_BYTES: begin
                    max_bytes_next = (cfg_wr_data == '0) ? DEF_MAX_BYTES : cfg_wr_data;
                end
                CFG_RESEND_GAP: gap_next = cfg_wr_data[15:0];
                default: ;
            endcase
        end

        case (state_reg)
            ST_SWEEP: begin
                slot_we       = 1'b1;
                slot_waddr    = scan_idx_reg[SAW-1:0];
                slot_wdata    = '0;
                scan_idx_next = scan_idx_reg + 1'b1;
            end
            ST_IDLE: begin
                req_next    = s_tuser;
                sid_next    = s_tdata[31:0];
                seq_next    = s_tdata[47:32];
                len_next    = s_tdata[63:48];
                handle_next = s_tdata[95:64];
                now_next    = s_tdata[127:96];
                hh_next     = '0;
                hl_next     = '0;
                mode_next   = WM_AGE;
                post_next   = 1'b0;
                if (s_tvalid) begin
                    if (s_tuser == REQ_CLEAR) begin
                        status_next   = STAT_CLEARED;
                        clr_resp_next = 1'b1;
                        scan_idx_next = '0;
                        head_next     = '0;
                        fill_next     = '0;
                        serial_next   = 32'd1;
                        entries_next  = '0;
                        bytes_next    = '0;
                        ins_next      = '0;
                        rep_next      = '0;
                        age_cnt_next  = '0;
                        cap_cnt_next  = '0;
                    end else if (s_tuser == REQ_STORE) begin
                        status_next = STAT_IGNORED;
                    end else if (s_tuser == REQ_LOOKUP) begin
                        status_next = STAT_MISS;
                    end else begin
                        status_next = STAT_REPORTED;
                    end
                end
            end
            ST_WCHK: begin
                if (walk_go) begin
                    ring_re = 1'b1;
                end else if (mode_reg == WM_AGE) begin
                    mode_next = WM_CAP;
                end else if (mode_reg == WM_CAP && !post_reg &&
                             req_reg == REQ_STORE && fill_reg == RING_FULL) begin
                    mode_next = WM_OVF;
                end else if (mode_reg == WM_FULL) begin
                    cur_slot_next = free_slot_reg;
                end
            end
            ST_WRING: begin
                slot_re = 1'b1;
            end
            ST_WSLOT: begin
                if (mode_reg == WM_AGE && live && !too_old) begin
                    mode_next = WM_CAP;
                end else begin
                    head_next = head_inc;
                    fill_next = fill_reg - 1'b1;
                    if (live) begin
                        slot_we      = 1'b1;
                        slot_waddr   = rec_slot;
                        slot_wdata   = {1'b0, slot_rdata[SLOT_W-2:0]};
                        bytes_next   = bytes_reg - 32'(sw.length);
                        entries_next = entries_reg - 1'b1;
                        if (mode_reg == WM_AGE) begin
                            age_cnt_next = age_cnt_reg + 1'b1;
                        end else begin
                            cap_cnt_next = cap_cnt_reg + 1'b1;
                        end
                        if (mode_reg == WM_FULL) begin
                            cur_slot_next = rec_slot;
                            found_next    = 1'b0;
                        end
                    end
                end
            end
            ST_SCAN: begin
                if (scan_idx_reg < SLOT_CNT) begin
                    slot_re       = 1'b1;
                    slot_raddr    = scan_idx_reg[SAW-1:0];
                    scan_idx_next = scan_idx_reg + 1'b1;
                    pend_next     = 1'b1;
                end else begin
                    pend_next = 1'b0;
                end
                pend_idx_next = scan_idx_reg[SAW-1:0];
                seen_next     = seen_after;
                if (pend_reg && !sw.valid && !free_found_reg) begin
                    free_found_next = 1'b1;
                    free_slot_next  = pend_idx_reg;
                end
                if (pd_match) begin
                    found_next    = 1'b1;
                    cur_next      = sw;
                    cur_slot_next = pend_idx_reg;
                end else if (scan_end && !is_lookup) begin
                    found_next    = 1'b0;
                    cur_slot_next = free_found_reg ? free_slot_reg : pend_idx_reg;
                    if (!free_after) begin
                        mode_next = WM_FULL;
                    end
                end
            end
            ST_STORE: begin
                slot_we    = 1'b1;
                slot_wdata = {1'b1, key, handle_reg, len_reg, now_reg, 1'b0, 32'd0,
                              serial_reg};
                ring_we    = 1'b1;
                serial_next = serial_reg + 1'b1;
                fill_next   = fill_reg + 1'b1;
                if (found_reg) begin
                    bytes_next  = bytes_reg - 32'(cur_reg.length) + 32'(len_reg);
                    rep_next    = rep_reg + 1'b1;
                    status_next = STAT_REPLACED;
                end else begin
                    bytes_next   = bytes_reg + 32'(len_reg);
                    entries_next = entries_reg + 1'b1;
                    ins_next     = ins_reg + 1'b1;
                    status_next  = STAT_INSERTED;
                end
                post_next = 1'b1;
                mode_next = WM_AGE;
            end
            ST_LOOK: begin
                if (cur_reg.rflag && ((now_reg - cur_reg.rtime) < 32'(gap_reg))) begin
                    status_next = STAT_SUPPRESSED;
                end else begin
                    slot_we     = 1'b1;
                    slot_wdata  = {cur_reg.valid, cur_reg.key, cur_reg.handle,
                                   cur_reg.length, cur_reg.stored, 1'b1, now_reg,
                                   cur_reg.serial};
                    hh_next     = cur_reg.handle;
                    hl_next     = cur_reg.length;
                    status_next = STAT_HIT;
                end
            end
            ST_RESP: begin
                if (!m_valid_reg || m_tready) begin
                    m_valid_next  = 1'b1;
                    m_user_next   = status_reg;
                    m_data_next   = {2'b00, cap_cnt_reg, age_cnt_reg, rep_reg, ins_reg,
                                     bytes_reg, entries32[13:0], hl_reg, hh_reg};
                    clr_resp_next = 1'b0;
                end
            end
            default: ;
        endcase

        if (state_next == ST_SCAN && state_reg != ST_SCAN) begin
            scan_idx_next   = '0;
            pend_next       = 1'b0;
            seen_next       = '0;
            free_found_next = 1'b0;
            found_next      = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_SWEEP;
            mode_reg       <= WM_AGE;
            post_reg       <= 1'b0;
            clr_resp_reg   <= 1'b0;
            max_age_reg    <= DEF_MAX_AGE;
            max_ent_reg    <= DEF_MAX_ENTRIES;
            max_bytes_reg  <= DEF_MAX_BYTES;
            gap_reg        <= '0;
            head_reg       <= '0;
            fill_reg       <= '0;
            serial_reg     <= 32'd1;
            entries_reg    <= '0;
            bytes_reg      <= '0;
            ins_reg        <= '0;
            rep_reg        <= '0;
            age_cnt_reg    <= '0;
            cap_cnt_reg    <= '0;
            scan_idx_reg   <= '0;
            pend_reg       <= 1'b0;
            seen_reg       <= '0;
            free_found_reg <= 1'b0;
            found_reg      <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            state_reg      <= state_next;
            mode_reg       <= mode_next;
            post_reg       <= post_next;
            clr_resp_reg   <= clr_resp_next;
            max_age_reg    <= max_age_next;
            max_ent_reg    <= max_ent_next;
            max_bytes_reg  <= max_bytes_next;
            gap_reg        <= gap_next;
            head_reg       <= head_next;
            fill_reg       <= fill_next;
            serial_reg     <= serial_next;
            entries_reg    <= entries_next;
            bytes_reg      <= bytes_next;
            ins_reg        <= ins_next;
            rep_reg        <= rep_next;
            age_cnt_reg    <= age_cnt_next;
            cap_cnt_reg    <= cap_cnt_next;
            scan_idx_reg   <= scan_idx_next;
            pend_reg       <= pend_next;
            seen_reg       <= seen_next;
            free_found_reg <= free_found_next;
            found_reg      <= found_next;
            m_valid_reg    <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        pend_idx_reg  <= pend_idx_next;
        free_slot_reg <= free_slot_next;
        cur_reg       <= cur_next;
        cur_slot_reg  <= cur_slot_next;
        req_reg       <= req_next;
        sid_reg       <= sid_next;
        seq_reg       <= seq_next;
        len_reg       <= len_next;
        handle_reg    <= handle_next;
        now_reg       <= now_next;
        status_reg    <= status_next;
        hh_reg        <= hh_next;
        hl_reg        <= hl_next;
        m_data_reg    <= m_data_next;
        m_user_reg    <= m_user_next;
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_user_reg;

endmodule
